// ===== design/assert_macros.svh =====
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BQN_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BQN_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define BQN_ASSERT(name, prop)
`define BQN_ASSERT_RST(name, prop)
`endif
`endif

// ===== design/bqn_pkg.sv =====
package bqn_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int CHAN_W     = 3;
  localparam int COEF_W     = 20;
  localparam int DELAY_W    = 32;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = COEF_W + DELAY_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int REG_IDX_W  = 3;
  localparam int STEP_W     = 4;

  localparam logic signed [COEF_W-1:0] COEF_B0_RST = 20'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_B1_RST = '0;
  localparam logic signed [COEF_W-1:0] COEF_B2_RST = '0;
  localparam logic signed [COEF_W-1:0] COEF_A1_RST = '0;
  localparam logic signed [COEF_W-1:0] COEF_A2_RST = '0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_LOAD   = 4'd1;
  localparam step_t STEP_FB2    = 4'd2;
  localparam step_t STEP_FB_SUM = 4'd3;
  localparam step_t STEP_RND_W  = 4'd4;
  localparam step_t STEP_FF0    = 4'd5;
  localparam step_t STEP_FF1    = 4'd6;
  localparam step_t STEP_FF2    = 4'd7;
  localparam step_t STEP_FF_SUM = 4'd8;
  localparam step_t STEP_OUT    = 4'd9;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_A1_RD,
    MUL_A2_W2,
    MUL_B0_W,
    MUL_B1_W1,
    MUL_B2_W2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_ADD,
    ACC_LOAD_P
  } acc_op_t;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_BR_BAD,
    SEQ_WAIT_OUT,
    SEQ_JUMP
  } seq_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    logic     ld_dly;
    logic     rnd_w;
    logic     wr_dly;
    seq_t     seq;
    step_t    target;
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t u;
    u = '{mul: MUL_NONE, acc: ACC_HOLD, ld_dly: 1'b0, rnd_w: 1'b0, wr_dly: 1'b0,
          seq: SEQ_NEXT, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        u.seq = SEQ_WAIT_IN;
      end
      STEP_LOAD: begin
        u.ld_dly = 1'b1;
        u.mul    = MUL_A1_RD;
        u.acc    = ACC_LOAD_X;
        u.seq    = SEQ_BR_BAD;
        u.target = STEP_OUT;
      end
      STEP_FB2: begin
        u.mul = MUL_A2_W2;
        u.acc = ACC_SUB;
      end
      STEP_FB_SUM: begin
        u.acc = ACC_SUB;
      end
      STEP_RND_W: begin
        u.rnd_w = 1'b1;
      end
      STEP_FF0: begin
        u.mul    = MUL_B0_W;
        u.wr_dly = 1'b1;
      end
      STEP_FF1: begin
        u.mul = MUL_B1_W1;
        u.acc = ACC_LOAD_P;
      end
      STEP_FF2: begin
        u.mul = MUL_B2_W2;
        u.acc = ACC_ADD;
      end
      STEP_FF_SUM: begin
        u.acc = ACC_ADD;
      end
      STEP_OUT: begin
        u.seq    = SEQ_WAIT_OUT;
        u.target = STEP_IDLE;
      end
      default: begin
        u.seq    = SEQ_JUMP;
        u.target = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== design/bqn_ram.sv =====
module bqn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/biquad_df2_notch_filter_top.sv =====
// Multi-channel direct form II biquad. Each input transaction carries one sample
// (in_tdata) and its channel (in_tuser); each produces exactly one output
// transaction with the filtered, saturated sample and the same channel. A short
// microcode program drives one shared 20x32 multiplier and one accumulator: each
// item runs the steps from LOAD to OUT to reach the output register, and the next
// item is accepted only back in IDLE; a channel at or above NUM_CHANNELS jumps from
// LOAD to OUT and returns a zero sample without touching any delay. A result still
// waiting in the output register holds the program at its last step until the output
// side takes it. The per-channel delay pair sits in one RAM word read once and
// written once per item. Coefficients (signed Q3.16) are written through the cfg
// port; the user must write them only while idle, as the block does not check it.
`include "assert_macros.svh"

module biquad_df2_notch_filter_top
  import bqn_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // sample_in
  input  logic [CHAN_W-1:0]    in_tuser,   // chan_in
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // sample_out
  output logic [CHAN_W-1:0]    out_tuser,  // chan_out
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RAM_W  = 2 * DELAY_W;
  localparam int RND_W  = ACC_W - FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  step_t                     step_r, step_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [CHAN_W-1:0]         chan_r;
  logic [ADDR_W-1:0]         addr_r;
  logic                      chan_ok_r;
  logic                      vld_rd_r;
  logic [NUM_CHANNELS-1:0]   vld_r;
  logic signed [DELAY_W-1:0] w1_r, w2_r, w_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r;
  logic [SAMPLE_BITS-1:0]    out_sample_r;
  logic [CHAN_W-1:0]         out_chan_r;

  uword_t                    uw;
  logic                      in_fire;
  logic                      out_free;
  logic                      in_ok;
  logic [CHAN_W+ADDR_W-1:0]  in_chan_ext;
  logic [ADDR_W-1:0]         rd_addr;
  logic [RAM_W-1:0]          rd_data;
  logic signed [DELAY_W-1:0] rd_w1, rd_w2;
  logic signed [COEF_W-1:0]  mul_c;
  logic signed [DELAY_W-1:0] mul_d;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [RND_W-1:0]   rnd;
  logic [RND_W-DELAY_W:0]    w_hi;
  logic [RND_W-SAMPLE_BITS:0] y_hi;
  logic signed [DELAY_W-1:0] w_sat;
  logic [SAMPLE_BITS-1:0]    y_sat;

  assign uw          = ucode(step_r);
  assign in_tready   = (uw.seq == SEQ_WAIT_IN);
  assign in_fire     = in_tvalid & in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign cfg_ready   = 1'b1;

  assign in_ok       = (int'(in_tuser) < NUM_CHANNELS);
  assign in_chan_ext = {{ADDR_W{1'b0}}, in_tuser};
  assign rd_addr     = in_ok ? in_chan_ext[ADDR_W-1:0] : '0;

  bqn_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_CHANNELS)
  ) u_dly_ram (
    .clk   (clk),
    .we    (uw.wr_dly),
    .waddr (addr_r),
    .wdata ({w1_r, w_r}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_w1 = vld_rd_r ? signed'(rd_data[DELAY_W-1:0])       : '0;
  assign rd_w2 = vld_rd_r ? signed'(rd_data[RAM_W-1:DELAY_W])   : '0;

  always_comb begin
    case (uw.mul)
      MUL_A1_RD: begin mul_c = a1_r; mul_d = rd_w1; end
      MUL_A2_W2: begin mul_c = a2_r; mul_d = w2_r;  end
      MUL_B0_W:  begin mul_c = b0_r; mul_d = w_r;   end
      MUL_B1_W1: begin mul_c = b1_r; mul_d = w1_r;  end
      MUL_B2_W2: begin mul_c = b2_r; mul_d = w2_r;  end
      default:   begin mul_c = '0;   mul_d = '0;    end
    endcase
    prod_nxt = mul_c * mul_d;
  end

  always_comb begin
    case (uw.acc)
      ACC_LOAD_X: acc_nxt = ACC_W'(x_r) <<< FRAC_SHIFT;
      ACC_SUB:    acc_nxt = acc_r - ACC_W'(prod_r);
      ACC_ADD:    acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_LOAD_P: acc_nxt = ACC_W'(prod_r);
      default:    acc_nxt = acc_r;
    endcase
  end

  // round half up, then clamp
  assign rnd_sum = acc_r + ROUND_HALF;
  assign rnd     = rnd_sum[ACC_W-1:FRAC_SHIFT];
  assign w_hi    = rnd[RND_W-1:DELAY_W-1];
  assign y_hi    = rnd[RND_W-1:SAMPLE_BITS-1];
  assign w_sat   = ((&w_hi) || !(|w_hi)) ? rnd[DELAY_W-1:0]
                 : {rnd[RND_W-1], {(DELAY_W-1){~rnd[RND_W-1]}}};
  assign y_sat   = ((&y_hi) || !(|y_hi)) ? rnd[SAMPLE_BITS-1:0]
                 : {rnd[RND_W-1], {(SAMPLE_BITS-1){~rnd[RND_W-1]}}};

  always_comb begin
    case (uw.seq)
      SEQ_NEXT:     step_nxt = step_t'(step_r + 1'b1);
      SEQ_WAIT_IN:  step_nxt = in_fire ? step_t'(step_r + 1'b1) : step_r;
      SEQ_BR_BAD:   step_nxt = chan_ok_r ? step_t'(step_r + 1'b1) : uw.target;
      SEQ_WAIT_OUT: step_nxt = out_free ? uw.target : step_r;
      SEQ_JUMP:     step_nxt = uw.target;
      default:      step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= COEF_B0_RST;
      b1_r <= COEF_B1_RST;
      b2_r <= COEF_B2_RST;
      a1_r <= COEF_A1_RST;
      a2_r <= COEF_A2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_B0:  b0_r <= cfg_data;
        REG_B1:  b1_r <= cfg_data;
        REG_B2:  b2_r <= cfg_data;
        REG_A1:  a1_r <= cfg_data;
        REG_A2:  a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (uw.wr_dly) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (uw.seq == SEQ_WAIT_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r       <= in_tdata[SAMPLE_BITS-1:0];
      chan_r    <= in_tuser;
      addr_r    <= rd_addr;
      chan_ok_r <= in_ok;
      vld_rd_r  <= vld_r[rd_addr];
    end
    if (uw.ld_dly) begin
      w1_r <= rd_w1;
      w2_r <= rd_w2;
    end
    if (uw.rnd_w) begin
      w_r <= w_sat;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (uw.seq == SEQ_WAIT_OUT && out_free) begin
      out_sample_r <= chan_ok_r ? y_sat : '0;
      out_chan_r   <= chan_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_sample_r);
  assign out_tuser  = out_chan_r;

  `BQN_ASSERT(a_load_after_accept, in_tvalid && in_tready |=> step_r == STEP_LOAD)
  `BQN_ASSERT(a_wr_good_chan, uw.wr_dly |-> chan_ok_r)
  `BQN_ASSERT(a_out_from_seq, $rose(out_valid_r) |-> $past(step_r) == STEP_OUT)
  `BQN_ASSERT(a_bad_chan_zero, step_r == STEP_OUT && out_free && !chan_ok_r |=> out_sample_r == '0)
  `BQN_ASSERT_RST(a_idle_after_reset, !rst_n |=> step_r == STEP_IDLE && !out_valid_r)

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqn_pkg::*;

  localparam int NUM_CH   = NUM_CHANNELS_DEF;
  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int REG_COUNT = 5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;

  localparam int GAP_MAX        = 17;
  localparam int SEGMENTS       = 10;
  localparam int SEG_ITEMS      = 43;
  localparam int HOLD_AT        = 230;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum int {
    COEFS_RANDOM,
    COEFS_STABLE,
    COEFS_EXTREME,
    COEFS_RESET
  } coef_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   chan;
  } filt_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    coef;
    logic [SAMPLE_W-1:0]  sample;
    logic [CHAN_W-1:0]    chan;
    logic                 known;
    logic [SAMPLE_W-1:0]  known_out;
  } stim_row_t;

  localparam int NROWS = 26;

  stim_row_t dir_rows [NROWS] = '{
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd0, 1'b1, 24'h7FFFFF},
    '{1'b0, REG_B0, 20'h00000, 24'h800000, 3'd1, 1'b1, 24'h800000},
    '{1'b0, REG_B0, 20'h00000, 24'h000000, 3'd2, 1'b1, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'hFFFFFF, 3'd7, 1'b1, 24'hFFFFFF},
    '{1'b0, REG_B0, 20'h00000, 24'h000001, 3'd3, 1'b1, 24'h000001},
    '{1'b1, REG_B0, 20'h7FFFF, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd4, 1'b1, 24'h7FFFFF},
    '{1'b0, REG_B0, 20'h00000, 24'h800000, 3'd5, 1'b1, 24'h800000},
    '{1'b0, REG_B0, 20'h00000, 24'h000001, 3'd6, 1'b0, 24'h000000},
    '{1'b1, REG_B0, 20'h80000, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd0, 1'b1, 24'h800000},
    '{1'b0, REG_B0, 20'h00000, 24'h800000, 3'd1, 1'b1, 24'h7FFFFF},
    '{1'b1, REG_B0, 20'h10000, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b1, REG_A1, 20'h80000, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd2, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd2, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd2, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h7FFFFF, 3'd2, 1'b0, 24'h000000},
    '{1'b1, REG_B1, 20'h7FFFF, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b1, REG_B2, 20'h80000, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b1, REG_A2, 20'h7FFFF, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h800000, 3'd2, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h800000, 3'd3, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'hABCDEF, 3'd7, 1'b0, 24'h000000},
    '{1'b1, REG_SPARE, 20'hFFFFF, 24'h000000, 3'd0, 1'b0, 24'h000000},
    '{1'b0, REG_B0, 20'h00000, 24'h000100, 3'd4, 1'b0, 24'h000000}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata = '0;
  logic [CHAN_W-1:0]    in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;
  logic [CHAN_W-1:0]    out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  logic signed [COEF_W-1:0] coef_reg [REG_COUNT] =
    '{COEF_B0_RST, COEF_B1_RST, COEF_B2_RST, COEF_A1_RST, COEF_A2_RST};
  longint dly_one [NUM_CH] = '{default: 0};
  longint dly_two [NUM_CH] = '{default: 0};

  filt_result_t pending_q [$];
  int items_sent = 0;
  int res_count  = 0;
  int cfg_writes = 0;
  int errors     = 0;

  biquad_df2_notch_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint q16_round(input longint acc);
    return (acc + 64'sd32768) >>> FRAC_SHIFT;
  endfunction

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] biquad_predict(input logic [SAMPLE_W-1:0] x_bits,
                                                          input logic [CHAN_W-1:0] ch);
    longint x;
    longint w1;
    longint w2;
    longint w;
    longint y;
    if (int'(ch) >= NUM_CH) return '0;
    x  = longint'($signed(x_bits));
    w1 = dly_one[ch];
    w2 = dly_two[ch];
    w = clamp_bits(q16_round((x <<< FRAC_SHIFT) - longint'(coef_reg[REG_A1]) * w1
                             - longint'(coef_reg[REG_A2]) * w2), DELAY_W);
    y = clamp_bits(q16_round(longint'(coef_reg[REG_B0]) * w + longint'(coef_reg[REG_B1]) * w1
                             + longint'(coef_reg[REG_B2]) * w2), SAMPLE_W);
    dly_two[ch] = w1;
    dly_one[ch] = w;
    return SAMPLE_W'(y);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input coef_mode_t mode, input reg_idx_t r);
    logic [COEF_W-1:0] c;
    case (mode)
      COEFS_RANDOM: begin
        c = COEF_W'($urandom);
      end
      COEFS_STABLE: begin
        case (r)
          REG_B0, REG_B2: c = COEF_W'($urandom_range(32768, 65536));
          REG_B1: c = COEF_W'($urandom_range(0, 262143)) - COEF_W'(131072);
          REG_A1: c = COEF_W'($urandom_range(0, 240000)) - COEF_W'(120000);
          default: c = COEF_W'($urandom_range(0, 60000));
        endcase
      end
      COEFS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: c = {1'b0, {(COEF_W-1){1'b1}}};
          1: c = {1'b1, {(COEF_W-1){1'b0}}};
          2: c = '0;
          default: c = COEF_B0_RST;
        endcase
      end
      default: begin
        case (r)
          REG_B0: c = COEF_B0_RST;
          REG_B1: c = COEF_B1_RST;
          REG_B2: c = COEF_B2_RST;
          REG_A1: c = COEF_A1_RST;
          default: c = COEF_A2_RST;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
      2, 3, 4: s = SAMPLE_W'($urandom_range(0, 2047)) - SAMPLE_W'(1024);
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // entered and left at a falling edge; valid stays high for a back-to-back item
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] ch,
                             input int gap, input logic known,
                             input logic [SAMPLE_W-1:0] known_out);
    filt_result_t r;
    logic [SAMPLE_W-1:0] y;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(s);
    in_tuser  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    y = biquad_predict(s, ch);
    r.sample = known ? known_out : y;
    r.chan   = ch;
    pending_q.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < REG_COUNT) coef_reg[idx] = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int stall;
    bit burst;
    filt_result_t exp_r;
    burst = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (res_count % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, GAP_MAX);
      if (res_count == HOLD_AT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, actual sample %h chan %0d", $time,
                 out_tdata[SAMPLE_W-1:0], out_tuser);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== exp_r.sample || out_tuser !== exp_r.chan) begin
          errors++;
          $display("%0t: mismatch, expected sample %h chan %0d, actual sample %h chan %0d",
                   $time, exp_r.sample, exp_r.chan, out_tdata[SAMPLE_W-1:0], out_tuser);
        end
      end
      res_count++;
      @(negedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit burst;
    coef_mode_t mode;
    burst = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_coef(dir_rows[i].idx, dir_rows[i].coef);
      else
        send_sample(dir_rows[i].sample, dir_rows[i].chan, $urandom_range(0, GAP_MAX),
                    dir_rows[i].known, dir_rows[i].known_out);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mode = coef_mode_t'(seg % 4);
      for (int r = 0; r < REG_COUNT; r++)
        write_coef(REG_IDX_W'(r), pick_coef(mode, reg_idx_t'(r)));
      if (seg % 3 == 0)
        write_coef(REG_IDX_W'($urandom_range(REG_COUNT, (1 << REG_IDX_W) - 1)),
                   COEF_W'($urandom));
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i % 16 == 0) burst = ($urandom_range(0, 2) == 0);
        if (seg == 5 && i == SEG_ITEMS / 2) begin
          wait_drained();
          @(negedge clk);
        end
        send_sample(pick_sample(), CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1)),
                    burst ? 0 : $urandom_range(0, GAP_MAX), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d samples over %0d channels with %0d coefficient writes",
             items_sent, NUM_CH, cfg_writes);
    $display("(identity, saturating extremes, random and stable filters); %0d results checked",
             res_count);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== biquad_df2_notch_filter_top.f =====
+incdir+design
design/bqn_pkg.sv
design/bqn_ram.sv
design/biquad_df2_notch_filter_top.sv
dv/tb.sv
